[hw/rtl/sha1md_pkg.sv]
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared beat types, controller command and status types and hash constants
// for the byte-serial SHA-1 digest core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1md_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_CHAIN  = 5;
   localparam int NUM_SCHED  = 16;
   localparam int NUM_ROUNDS = 80;
   localparam int ROUND_W    = 7;
   localparam int FILL_W     = 6;
   localparam int MSG_LEN_W  = 61;
   localparam int IDX_W      = 3;

   localparam int PHASE1_END = 20;
   localparam int PHASE2_END = 40;
   localparam int PHASE3_END = 60;

   localparam logic [WORD_W-1:0] K_PHASE1 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K_PHASE2 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K_PHASE3 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K_PHASE4 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   // fill levels that matter to the controller
   localparam logic [FILL_W-1:0] FILL_LAST    = 6'd63;
   localparam logic [FILL_W-1:0] FILL_PRE_LEN = 6'd55;

   localparam logic [WORD_W-1:0] H_INIT [NUM_CHAIN] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // byte source for the packer
   localparam logic [1:0] PUT_NONE  = 2'd0;
   localparam logic [1:0] PUT_DATA  = 2'd1;
   localparam logic [1:0] PUT_PAD80 = 2'd2;
   localparam logic [1:0] PUT_ZERO  = 2'd3;

   // length word select
   localparam logic [1:0] LEN_NONE = 2'd0;
   localparam logic [1:0] LEN_HI   = 2'd1;
   localparam logic [1:0] LEN_LO   = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic [IDX_W-1:0]  word_index;
      logic              last;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]         put_src;
      logic [1:0]         len_word;
      logic               count_byte;
      logic               load_vars;
      logic               round_en;
      logic [ROUND_W-1:0] round;
      logic               add_chain;
      logic               emit_en;
      logic [IDX_W-1:0]   emit_idx;
      logic               clear_msg;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_pre_len;
   } status_type;

endpackage

[hw/rtl/sha1md_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: byte intake, padding, length words, the 80 compression rounds,
// chain update and digest emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1md_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_stall,
   input  logic                    out_free,
   input  sha1md_pkg::status_type  status,
   output sha1md_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROUND  = 3'd1;
   localparam logic [2:0] ST_ADD    = 3'd2;
   localparam logic [2:0] ST_PAD    = 3'd3;
   localparam logic [2:0] ST_LEN_HI = 3'd4;
   localparam logic [2:0] ST_LEN_LO = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   localparam logic [2:0] LAST_IDX = 3'(sha1md_pkg::NUM_CHAIN - 1);
   localparam logic [sha1md_pkg::ROUND_W-1:0] LAST_ROUND =
      sha1md_pkg::ROUND_W'(sha1md_pkg::NUM_ROUNDS - 1);

   logic [2:0]                       state_ff, state_in;
   logic [2:0]                       ret_ff, ret_in;
   logic                             pad_first_ff, pad_first_in;
   logic [sha1md_pkg::ROUND_W-1:0]   round_ff, round_in;
   logic [sha1md_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic                             accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pad_first_in = pad_first_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.put_src  = sha1md_pkg::PUT_NONE;
      cmd.len_word = sha1md_pkg::LEN_NONE;
      cmd.round    = round_ff;
      cmd.emit_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_kind) begin
                  cmd.put_src    = sha1md_pkg::PUT_DATA;
                  cmd.count_byte = 1'b1;
                  if (status.fill_last) begin
                     cmd.load_vars = 1'b1;
                     ret_in        = ST_IDLE;
                     state_in      = ST_ROUND;
                  end
               end else begin
                  pad_first_in = 1'b1;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.put_src  = pad_first_ff ? sha1md_pkg::PUT_PAD80 : sha1md_pkg::PUT_ZERO;
            pad_first_in = 1'b0;
            if (status.fill_pre_len) begin
               state_in = ST_LEN_HI;
            end else if (status.fill_last) begin
               cmd.load_vars = 1'b1;
               ret_in        = ST_PAD;
               state_in      = ST_ROUND;
            end
         end
         ST_LEN_HI: begin
            cmd.len_word = sha1md_pkg::LEN_HI;
            state_in     = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            cmd.len_word  = sha1md_pkg::LEN_LO;
            cmd.load_vars = 1'b1;
            ret_in        = ST_EMIT;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff == LAST_ROUND) begin
               round_in = '0;
               state_in = ST_ADD;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            state_in      = ret_ff;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit_en = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  cmd.clear_msg = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pad_first_ff <= 1'b0;
         round_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pad_first_ff <= pad_first_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
      end
   end

`ifndef SYNTHESIS
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff <= LAST_ROUND))
      else $error("round counter beyond last round");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> out_free)
      else $error("digest word loaded into a full output register");

   a_len_then_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN_LO) |=> (state_ff == ST_ROUND) && (ret_ff == ST_EMIT))
      else $error("final block did not start its compression");

   a_last_word_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_en && (idx_ff == LAST_IDX)) |=> (state_ff == ST_IDLE) && (idx_ff == '0))
      else $error("controller not idle after the last digest word");
`endif

endmodule

[hw/rtl/sha1md_dp.sv]
// ----------------------------------------------------------------------------
// sha1md_dp
// Datapath: byte packer, 16-word schedule shift line, round variables,
// round function, chain words and message length counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1md_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sha1md_pkg::cmd_type                 cmd,
   input  logic [7:0]                          data_byte,
   output sha1md_pkg::status_type              status,
   output logic [sha1md_pkg::WORD_W-1:0]       digest_word
);

   localparam int W = sha1md_pkg::WORD_W;

   logic [W-1:0]                     chain_ff [sha1md_pkg::NUM_CHAIN];
   logic [W-1:0]                     vars_ff  [sha1md_pkg::NUM_CHAIN];
   logic [W-1:0]                     sched_ff [sha1md_pkg::NUM_SCHED];
   logic [23:0]                      acc_ff;
   logic [sha1md_pkg::FILL_W-1:0]    fill_ff;
   logic [sha1md_pkg::MSG_LEN_W-1:0] msg_ff;

   logic [7:0]   put_byte;
   logic         put_en;
   logic         word_done;
   logic [W-1:0] packed_word;
   logic [63:0]  bit_len;
   logic         shift_en;
   logic [W-1:0] shift_word;
   logic [W-1:0] sched_next;
   logic [W-1:0] f_val;
   logic [W-1:0] k_val;
   logic [W-1:0] t_val;

   assign status.fill_last    = (fill_ff == sha1md_pkg::FILL_LAST);
   assign status.fill_pre_len = (fill_ff == sha1md_pkg::FILL_PRE_LEN);

   always_comb begin
      case (cmd.put_src)
         sha1md_pkg::PUT_DATA:  put_byte = data_byte;
         sha1md_pkg::PUT_PAD80: put_byte = sha1md_pkg::PAD_MARK;
         default:               put_byte = 8'h00;
      endcase
   end

   assign put_en      = (cmd.put_src != sha1md_pkg::PUT_NONE);
   assign word_done   = put_en && (fill_ff[1:0] == 2'b11);
   assign packed_word = {acc_ff, put_byte};
   assign bit_len     = {msg_ff, 3'b000};

   // schedule expansion on the sliding window, tap 0 is the current word
   assign sched_next = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];

   always_comb begin
      shift_en   = 1'b1;
      shift_word = {sched_next[W-2:0], sched_next[W-1]};
      if (cmd.round_en) begin
         shift_en = 1'b1;
      end else if (cmd.len_word == sha1md_pkg::LEN_HI) begin
         shift_word = bit_len[63:32];
      end else if (cmd.len_word == sha1md_pkg::LEN_LO) begin
         shift_word = bit_len[31:0];
      end else if (word_done) begin
         shift_word = packed_word;
      end else begin
         shift_en = 1'b0;
      end
   end

   always_comb begin
      if (cmd.round < sha1md_pkg::ROUND_W'(sha1md_pkg::PHASE1_END)) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (~vars_ff[1] & vars_ff[3]);
         k_val = sha1md_pkg::K_PHASE1;
      end else if (cmd.round < sha1md_pkg::ROUND_W'(sha1md_pkg::PHASE2_END)) begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = sha1md_pkg::K_PHASE2;
      end else if (cmd.round < sha1md_pkg::ROUND_W'(sha1md_pkg::PHASE3_END)) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (vars_ff[1] & vars_ff[3])
               | (vars_ff[2] & vars_ff[3]);
         k_val = sha1md_pkg::K_PHASE3;
      end else begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = sha1md_pkg::K_PHASE4;
      end
      t_val = {vars_ff[0][W-6:0], vars_ff[0][W-1:W-5]} + f_val + vars_ff[4]
            + k_val + sched_ff[0];
   end

   assign digest_word = chain_ff[cmd.emit_idx];

   // payload storage, no reset needed
   always_ff @(posedge clock) begin
      if (put_en) begin
         acc_ff <= {acc_ff[15:0], put_byte};
      end
      if (shift_en) begin
         for (int i = 0; i < sha1md_pkg::NUM_SCHED - 1; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[sha1md_pkg::NUM_SCHED-1] <= shift_word;
      end
      if (cmd.load_vars) begin
         for (int i = 0; i < sha1md_pkg::NUM_CHAIN; i++) begin
            vars_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_en) begin
         vars_ff[4] <= vars_ff[3];
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= {vars_ff[1][1:0], vars_ff[1][W-1:2]};
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_msg) begin
         for (int i = 0; i < sha1md_pkg::NUM_CHAIN; i++) begin
            chain_ff[i] <= sha1md_pkg::H_INIT[i];
         end
         fill_ff <= '0;
         msg_ff  <= '0;
      end else begin
         if (cmd.add_chain) begin
            for (int i = 0; i < sha1md_pkg::NUM_CHAIN; i++) begin
               chain_ff[i] <= chain_ff[i] + vars_ff[i];
            end
         end
         if (put_en) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.count_byte) begin
            msg_ff <= msg_ff + 1'b1;
         end
      end
   end

endmodule

[hw/rtl/sha1_message_digest_core.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 digest of a byte stream. Each req beat carries one message byte or a
// finish marker. The 64th data byte of a block starts the 80-round
// compression, run one round per cycle on a shared round unit and followed
// by the chain update, while req_stall holds off further beats. A finish
// beat pads one byte per cycle up to byte 56 of the block (with a further
// compression if the block overflows), writes the two length words,
// compresses once more and then delivers the five digest words H0..H4 as
// rsp beats, word 4 flagged last. The core then holds the initial chain
// values again and takes the next message; the last digest word may still
// sit in the output register while the next byte is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sha1md_pkg::req_payload_type   req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sha1md_pkg::rsp_payload_type   rsp_payload
);

   sha1md_pkg::cmd_type           cmd;
   sha1md_pkg::status_type        status;
   logic [sha1md_pkg::WORD_W-1:0] digest_word;
   logic                          out_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   sha1md_pkg::rsp_payload_type   rsp_payload_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   sha1md_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_stall (req_stall),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   sha1md_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_payload.data_byte),
      .status      (status),
      .digest_word (digest_word)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         rsp_payload_ff.digest_word <= digest_word;
         rsp_payload_ff.word_index  <= cmd.emit_idx;
         rsp_payload_ff.last        <=
            (cmd.emit_idx == sha1md_pkg::IDX_W'(sha1md_pkg::NUM_CHAIN - 1));
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[test/sha1_message_digest_core_tb.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest_core_tb
// Self-checking bench for the byte-serial SHA-1 core. A short table of beats
// covers the empty message, "abc", extreme byte values, back-to-back finishes
// and data straight after a finish. Random messages follow, a third of them
// with lengths around the padding boundary. Every digest word is compared field
// by field with an in-bench SHA-1 model, under random idling on both sides for the early part of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest_core_tb;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam int DIRECTED_ROWS  = 14;
   localparam int RANDOM_BEATS   = 130;
   localparam int RANDOM_WORDS   = 40;
   localparam int CALM_AFTER     = 100;
   localparam int STUCK_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic         kind;
      logic [7:0]   data_byte;
      logic         known;
      logic [159:0] digest;
   } stim_row_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   sha1md_pkg::req_payload_type req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   sha1md_pkg::rsp_payload_type rsp_payload;

   bit                          idling_on = 1'b1;
   int                          stall_left = 0;
   int                          stuck_cycles = 0;
   int                          mismatch_count = 0;
   int                          beats_sent = 0;
   int                          random_words = 0;
   sha1md_pkg::rsp_payload_type digest_words_due [$];
   stim_row_type                stim_rows [DIRECTED_ROWS];

   // model state
   logic [31:0]     chain_h [5];
   logic [31:0]     sched_w [16];
   logic [5:0]      fill_cnt;
   logic [60:0]     byte_count;

   sha1_message_digest_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 5; i++) chain_h[i] = sha1md_pkg::H_INIT[i];
      for (int i = 0; i < 16; i++) sched_w[i] = '0;
      fill_cnt   = '0;
      byte_count = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] a, b, c, d, e, f, k, t;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
         // schedule expanded in place over the 16-word ring
         if (r >= 16) begin
            sched_w[r % 16] = rol32(sched_w[(r + 13) % 16] ^ sched_w[(r + 8) % 16] ^
                                    sched_w[(r + 2) % 16] ^ sched_w[r % 16], 1);
         end
         if (r < sha1md_pkg::PHASE1_END) begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::K_PHASE1;
         end else if (r < sha1md_pkg::PHASE2_END) begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_PHASE2;
         end else if (r < sha1md_pkg::PHASE3_END) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::K_PHASE3;
         end else begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_PHASE4;
         end
         t = rol32(a, 5) + f + e + k + sched_w[r % 16];
         e = d;
         d = c;
         c = rol32(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void pack_byte(input logic [7:0] val);
      int sh;
      sh = 24 - 8 * fill_cnt[1:0];
      sched_w[fill_cnt[5:2]][sh +: 8] = val;
      fill_cnt = fill_cnt + 6'd1;
      if (fill_cnt == 6'd0) compress_block();
   endfunction

   function automatic void sha1_absorb(input sha1md_pkg::req_payload_type beat,
                                       output sha1md_pkg::rsp_payload_type words [5],
                                       output int n);
      logic [63:0] bit_len;
      n = 0;
      if (beat.kind == KIND_DATA) begin
         pack_byte(beat.data_byte);
         byte_count = byte_count + 61'd1;
      end else begin
         bit_len = {byte_count, 3'b000};
         pack_byte(sha1md_pkg::PAD_MARK);
         while (fill_cnt != 6'd56) pack_byte(8'h00);
         sched_w[14] = bit_len[63:32];
         sched_w[15] = bit_len[31:0];
         compress_block();
         for (int i = 0; i < 5; i++) begin
            words[i].digest_word = chain_h[i];
            words[i].word_index  = sha1md_pkg::IDX_W'(i);
            words[i].last        = (i == 4);
         end
         n = 5;
         restart_message();
      end
   endfunction

   task automatic send_beat(input sha1md_pkg::req_payload_type beat, input logic known,
                            input logic [159:0] digest);
      sha1md_pkg::rsp_payload_type fresh [5];
      sha1md_pkg::rsp_payload_type w;
      int n;
      int gap;
      gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      sha1_absorb(beat, fresh, n);
      for (int i = 0; i < n; i++) begin
         w = fresh[i];
         if (known) w.digest_word = digest[159 - 32 * i -: 32];
         digest_words_due.push_back(w);
      end
      if (beats_sent > DIRECTED_ROWS) random_words += n;
   endtask

   // sender holds off until every digest word due has been delivered
   task automatic drain_digests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (digest_words_due.size() != 0) @(posedge clock);
   endtask

   // receiver stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on && !reset && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      sha1md_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected digest beat: word %h index %0d last %b",
                        rsp_payload.digest_word, rsp_payload.word_index, rsp_payload.last);
         end else begin
            want = digest_words_due.pop_front();
            if (rsp_payload.digest_word !== want.digest_word ||
                rsp_payload.word_index !== want.word_index ||
                rsp_payload.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                           want.digest_word, want.word_index, want.last,
                           rsp_payload.digest_word, rsp_payload.word_index,
                           rsp_payload.last);
            end
         end
      end
   end

   // watchdog on cycles with no beat moving either way
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      sha1md_pkg::req_payload_type beat;
      int msg_len;
      stim_rows[0]  = '{KIND_FINISH, 8'h00, 1'b1,
                        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709};
      stim_rows[1]  = '{KIND_DATA,   8'h61, 1'b0, 160'h0};
      stim_rows[2]  = '{KIND_DATA,   8'h62, 1'b0, 160'h0};
      stim_rows[3]  = '{KIND_DATA,   8'h63, 1'b0, 160'h0};
      stim_rows[4]  = '{KIND_FINISH, 8'h00, 1'b1,
                        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d};
      // byte field ignored on finish, and a finish straight after a finish
      stim_rows[5]  = '{KIND_FINISH, 8'hFF, 1'b1,
                        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709};
      stim_rows[6]  = '{KIND_DATA,   8'h00, 1'b0, 160'h0};
      stim_rows[7]  = '{KIND_DATA,   8'hFF, 1'b0, 160'h0};
      stim_rows[8]  = '{KIND_DATA,   8'h55, 1'b0, 160'h0};
      stim_rows[9]  = '{KIND_DATA,   8'hAA, 1'b0, 160'h0};
      stim_rows[10] = '{KIND_FINISH, 8'h5A, 1'b0, 160'h0};
      stim_rows[11] = '{KIND_DATA,   8'h80, 1'b0, 160'h0};
      stim_rows[12] = '{KIND_DATA,   8'h01, 1'b0, 160'h0};
      stim_rows[13] = '{KIND_FINISH, 8'hA5, 1'b0, 160'h0};

      restart_message();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         beat.kind      = stim_rows[i].kind;
         beat.data_byte = stim_rows[i].data_byte;
         send_beat(beat, stim_rows[i].known, stim_rows[i].digest);
      end
      drain_digests();

      // random messages, a third of them near the one/two block padding split
      while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS || random_words < RANDOM_WORDS) begin
         if (idling_on && $urandom_range(0, 3) == 0) drain_digests();
         msg_len = ($urandom_range(0, 2) == 0) ? $urandom_range(52, 66) : $urandom_range(0, 20);
         for (int j = 0; j < msg_len; j++) begin
            beat.kind      = KIND_DATA;
            beat.data_byte = 8'($urandom_range(0, 255));
            send_beat(beat, 1'b0, '0);
         end
         beat.kind      = KIND_FINISH;
         beat.data_byte = 8'($urandom_range(0, 255));
         send_beat(beat, 1'b0, '0);
         if (beats_sent >= DIRECTED_ROWS + CALM_AFTER) idling_on = 1'b0;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (digest_words_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && digest_words_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
